/* src/mpq_pkg.sv */
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared constants and the state enumeration for the median
// partition quickselect block.
// ----------------------------------------------------------------------------
`default_nettype none
package mpq_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_BITS_DEF = 32;
    localparam int FIELD_W        = 32;
    localparam int IDX_W          = 6;
    localparam int AXIS_W         = 2;

    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;
    localparam logic [AXIS_W-1:0] AXIS_W_SEL = 2'd3;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_RANGE,
        ST_PIV_RD,
        ST_PIV_SWAP,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SCAN_SWAP,
        ST_FIN_SWAP,
        ST_FIN_WR,
        ST_EMIT_RD,
        ST_EMIT
    } state_t;

endpackage
`default_nettype wire

/* src/mpq_store.sv */
// ----------------------------------------------------------------------------
// mpq_store
// Point memory: two read ports and two write ports over registered arrays,
// one point (x, y, z, weight) per entry, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none
module mpq_store #(
    parameter int DEPTH = mpq_pkg::MAX_POINTS_DEF,
    parameter int AW    = 6
) (
    input  wire logic                  aclk,
    input  wire logic                  we_a,
    input  wire logic [AW-1:0]         wa_a,
    input  wire logic [4*32-1:0]       wd_a,
    input  wire logic                  we_b,
    input  wire logic [AW-1:0]         wa_b,
    input  wire logic [4*32-1:0]       wd_b,
    input  wire logic [AW-1:0]         ra_a,
    input  wire logic [AW-1:0]         ra_b,
    output logic      [4*32-1:0]       rd_a,
    output logic      [4*32-1:0]       rd_b
);
    logic [4*32-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we_a) begin
            mem[wa_a] <= wd_a;
        end
        if (we_b) begin
            mem[wa_b] <= wd_b;
        end
        rd_a <= mem[ra_a];
        rd_b <= mem[ra_b];
    end
endmodule
`default_nettype wire

/* src/median_partition_quickselect.sv */
// ----------------------------------------------------------------------------
// median_partition_quickselect
// Collects points, runs quickselect (middle pivot, Lomuto partition) so
// that entry floor(n/2) holds the median on the chosen axis, then streams
// every point out in the new order.
// Loading: one item per cycle; the last item hands over to selection in
// the next cycle. Selection: per round a setup (range, pivot read, pivot
// swap), a read and compare per scanned entry plus a swap when it swaps,
// then a close (final swap, write). Expect about 3.4n scanned entries;
// heavy ties degrade toward n*n. Emission: each item is read, then
// registered, a new one only while m_tready holds high or none is held.
// Reset (aresetn low, synchronous) clears count, overflow mark, axis and
// control; the store contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
module median_partition_quickselect #(
    parameter int MAX_POINTS = mpq_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = mpq_pkg::COORD_BITS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_wdata,        // split_axis
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,          // coord_x, coord_y, coord_z, point_weight
    input  wire logic         s_tlast,          // last_point
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [143:0]      m_tdata,          // out_index, out_x, out_y, out_z,
                                                // out_weight, median_position, overflow
    output logic              m_tlast           // last_result
);
    localparam int AW = 6;
    localparam int CW = 7;
    localparam int KB = (COORD_BITS < 32) ? COORD_BITS : 32;
    localparam logic [CW-1:0] MAXC = CW'(MAX_POINTS);

    mpq_pkg::state_t state_reg, state_next;

    logic [1:0]    axis_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [CW-1:0] i_reg, i_next, st_reg, st_next, last_reg, last_next;
    logic [31:0]   pv_reg, pv_next;
    logic          obuf_v_reg, obuf_v_next;
    logic [143:0]  obuf_reg, obuf_next;
    logic          obuf_l_reg, obuf_l_next;

    logic          we_a, we_b;
    logic [AW-1:0] wa_a, wa_b, ra_a, ra_b;
    logic [127:0]  wd_a, wd_b, rd_a, rd_b;

    mpq_store #(.DEPTH(MAX_POINTS), .AW(AW)) u_store (
        .aclk(aclk), .we_a(we_a), .wa_a(wa_a), .wd_a(wd_a),
        .we_b(we_b), .wa_b(wa_b), .wd_b(wd_b),
        .ra_a(ra_a), .ra_b(ra_b), .rd_a(rd_a), .rd_b(rd_b)
    );

    // trim one coordinate to KB bits, sign-extended
    function automatic logic [31:0] keep(input logic [31:0] v);
        logic [31:0] r;
        r = 32'($signed(v[KB-1:0]));
        return r;
    endfunction

    function automatic logic [31:0] key(input logic [127:0] p, input logic [1:0] ax);
        logic [31:0] r;
        case (ax)
            mpq_pkg::AXIS_X: r = p[31:0];
            mpq_pkg::AXIS_Y: r = p[63:32];
            mpq_pkg::AXIS_Z: r = p[95:64];
            default:         r = p[127:96];
        endcase
        return r;
    endfunction

    logic [CW-1:0] k_med;
    logic [CW-1:0] mid;
    logic [CW:0]   lohi;
    logic          less;
    assign k_med = cnt_reg >> 1;
    assign lohi  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid   = lohi[CW:1];
    assign less  = $signed(key(rd_a, axis_reg)) < $signed(pv_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            axis_reg <= '0;
        end else if (cfg_we) begin
            axis_reg <= cfg_wdata;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mpq_pkg::ST_LOAD: begin
                if (s_tvalid && s_tlast) begin
                    state_next = mpq_pkg::ST_RANGE;
                end
            end
            mpq_pkg::ST_RANGE: begin
                if (lo_reg < hi_reg) begin
                    state_next = mpq_pkg::ST_PIV_RD;
                end else begin
                    state_next = mpq_pkg::ST_EMIT_RD;
                end
            end
            mpq_pkg::ST_PIV_RD:   state_next = mpq_pkg::ST_PIV_SWAP;
            mpq_pkg::ST_PIV_SWAP: state_next = mpq_pkg::ST_SCAN_RD;
            mpq_pkg::ST_SCAN_RD: begin
                if (i_reg < last_reg) begin
                    state_next = mpq_pkg::ST_SCAN_CMP;
                end else begin
                    state_next = mpq_pkg::ST_FIN_SWAP;
                end
            end
            mpq_pkg::ST_SCAN_CMP: begin
                if (less && (i_reg != st_reg)) begin
                    state_next = mpq_pkg::ST_SCAN_SWAP;
                end else begin
                    state_next = mpq_pkg::ST_SCAN_RD;
                end
            end
            mpq_pkg::ST_SCAN_SWAP: state_next = mpq_pkg::ST_SCAN_RD;
            mpq_pkg::ST_FIN_SWAP:  state_next = mpq_pkg::ST_FIN_WR;
            mpq_pkg::ST_FIN_WR: begin
                if (st_reg == k_med) begin
                    state_next = mpq_pkg::ST_EMIT_RD;
                end else begin
                    state_next = mpq_pkg::ST_RANGE;
                end
            end
            mpq_pkg::ST_EMIT_RD: begin
                if (i_reg >= cnt_reg) begin
                    state_next = mpq_pkg::ST_LOAD;
                end else if (!obuf_v_reg || m_tready) begin
                    state_next = mpq_pkg::ST_EMIT;
                end
            end
            mpq_pkg::ST_EMIT: state_next = mpq_pkg::ST_EMIT_RD;
            default: state_next = mpq_pkg::ST_LOAD;
        endcase
    end

    // outputs and datapath
    always_comb begin
        cnt_next = cnt_reg;  ovf_next = ovf_reg;
        lo_next = lo_reg;    hi_next = hi_reg;
        i_next = i_reg;      st_next = st_reg;   last_next = last_reg;
        pv_next = pv_reg;
        obuf_v_next = obuf_v_reg; obuf_next = obuf_reg; obuf_l_next = obuf_l_reg;
        we_a = 1'b0; we_b = 1'b0;
        wa_a = '0; wa_b = '0; wd_a = rd_a; wd_b = rd_b;
        ra_a = i_reg[AW-1:0]; ra_b = st_reg[AW-1:0];
        s_tready = 1'b0;

        if (obuf_v_reg && m_tready) begin
            obuf_v_next = 1'b0;
        end

        case (state_reg)
            mpq_pkg::ST_LOAD: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (cnt_reg < MAXC) begin
                        we_a = 1'b1;
                        wa_a = cnt_reg[AW-1:0];
                        wd_a = {s_tdata[127:96], keep(s_tdata[95:64]),
                                keep(s_tdata[63:32]), keep(s_tdata[31:0])};
                        cnt_next = cnt_reg + 1'b1;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    lo_next = '0;
                    hi_next = (cnt_reg < MAXC) ? cnt_reg + 1'b1 : cnt_reg;
                end
            end
            mpq_pkg::ST_RANGE: begin
                last_next = hi_reg - 1'b1;
                ra_a = mid[AW-1:0];
                ra_b = last_next[AW-1:0];
                st_next = mid;
            end
            mpq_pkg::ST_PIV_RD: begin
                // rd_a = pivot point, rd_b = last point: swap them
                pv_next = key(rd_a, axis_reg);
                we_a = 1'b1; wa_a = last_reg[AW-1:0]; wd_a = rd_a;
                we_b = 1'b1; wa_b = st_reg[AW-1:0];   wd_b = rd_b;
            end
            mpq_pkg::ST_PIV_SWAP: begin
                i_next = lo_reg;
                st_next = lo_reg;
            end
            mpq_pkg::ST_SCAN_RD: begin
                ra_a = i_reg[AW-1:0];
                ra_b = st_reg[AW-1:0];
            end
            mpq_pkg::ST_SCAN_CMP: begin
                if (less) begin
                    if (i_reg != st_reg) begin
                        we_a = 1'b1; wa_a = st_reg[AW-1:0]; wd_a = rd_a;
                        we_b = 1'b1; wa_b = i_reg[AW-1:0];  wd_b = rd_b;
                    end
                    st_next = st_reg + 1'b1;
                end
                i_next = i_reg + 1'b1;
            end
            mpq_pkg::ST_SCAN_SWAP: begin
                // write settles before the next read
            end
            mpq_pkg::ST_FIN_SWAP: begin
                ra_a = last_reg[AW-1:0];
                ra_b = st_reg[AW-1:0];
            end
            mpq_pkg::ST_FIN_WR: begin
                we_a = 1'b1; wa_a = st_reg[AW-1:0];   wd_a = rd_a;
                we_b = 1'b1; wa_b = last_reg[AW-1:0]; wd_b = rd_b;
                if (st_reg < k_med) begin
                    lo_next = st_reg + 1'b1;
                end else if (st_reg > k_med) begin
                    hi_next = st_reg;
                end
                i_next = '0;
            end
            mpq_pkg::ST_EMIT_RD: begin
                ra_a = i_reg[AW-1:0];
                if (i_reg >= cnt_reg) begin
                    cnt_next = '0;
                    ovf_next = 1'b0;
                end
            end
            mpq_pkg::ST_EMIT: begin
                obuf_v_next = 1'b1;
                obuf_next = {3'b000, ovf_reg, k_med[AW-1:0], rd_a, i_reg[AW-1:0]};
                obuf_l_next = (i_reg + 1'b1 == cnt_reg);
                i_next = i_reg + 1'b1;
            end
            default: begin
            end
        endcase
        // cover sets that finish selection by empty range
        if (state_reg == mpq_pkg::ST_RANGE && !(lo_reg < hi_reg)) begin
            i_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= mpq_pkg::ST_LOAD;
            cnt_reg    <= '0;
            ovf_reg    <= 1'b0;
            obuf_v_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            ovf_reg    <= ovf_next;
            obuf_v_reg <= obuf_v_next;
        end
        lo_reg <= lo_next;  hi_reg <= hi_next;
        i_reg <= i_next;    st_reg <= st_next;  last_reg <= last_next;
        pv_reg <= pv_next;
        obuf_reg <= obuf_next; obuf_l_reg <= obuf_l_next;
    end

    assign m_tvalid = obuf_v_reg;
    assign m_tdata  = obuf_reg;
    assign m_tlast  = obuf_l_reg;
endmodule
`default_nettype wire

/* src/mpq_checker.sv */
// ----------------------------------------------------------------------------
// mpq_checker
// Port-level checks of the median partition quickselect block.
// ----------------------------------------------------------------------------
`default_nettype none
module mpq_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [143:0] m_tdata,
    input wire logic         m_tlast
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input taken during emission");
    a_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> !m_tvalid ||
        (m_tdata[5:0] == $past(m_tdata[5:0]) + 6'd1))
        else $error("result index skipped");
    a_med: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> !m_tvalid ||
        (m_tdata[139:134] == $past(m_tdata[139:134])))
        else $error("median position changed within a set");
endmodule

bind median_partition_quickselect mpq_checker u_mpq_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
`default_nettype wire
